[hdl/mmpbs_pkg.sv]
// shared types and codes for the masked multi-pattern byte search
package mmpbs_pkg;

    localparam int OPCODE_W   = 2;
    localparam int PIDX_W     = 3;
    localparam int EIDX_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int PLEN_W     = 5;
    localparam int GROUP_W    = 3;
    localparam int OFFSET_W   = 32;
    localparam int PCOUNT_W   = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_ELEM   = 2'd0,
        OP_LOAD_HEADER = 2'd1,
        OP_BYTE        = 2'd2,
        OP_NONE        = 2'd3
    } op_t;

    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PRIME,
        ST_CHECK,
        ST_SHIFT,
        ST_SUMMARY,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic in_take;
        logic rd_first;
        logic rd_next;
        logic hit_take;
        logic shift;
        logic sum_take;
        logic flush;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_b;
        logic fill_full;
        logic fill_one;
        logic fin;
        logic cnt_zero;
        logic hit;
        logic done;
        logic pend_valid;
        logic slot_free;
    } sts_t;

endpackage

[hdl/mmpbs_ctrl.sv]
// sequencing state machine for the byte search
module mmpbs_ctrl
    import mmpbs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [OPCODE_W-1:0] opcode,
    output logic                in_ready,
    input  sts_t                sts,
    output cmd_t                cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.in_take  = in_valid;
                if (in_valid && (op_t'(opcode) == OP_BYTE))
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!sts.last_b)
                begin
                    if (!sts.fill_full)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (sts.fin || sts.cnt_zero)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_PRIME;
                    end
                end
                else if (sts.fin || sts.cnt_zero)
                begin
                    state_next = ST_SUMMARY;
                end
                else
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                cmd.rd_first = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                // a hit waits while both result slots are full
                if (!(sts.hit && sts.pend_valid && !sts.slot_free))
                begin
                    cmd.hit_take = sts.hit;
                    if (sts.done)
                    begin
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            ST_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (!sts.last_b)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.fill_one || sts.fin || sts.cnt_zero)
                begin
                    state_next = ST_SUMMARY;
                end
                else
                begin
                    state_next = ST_PRIME;
                end
            end
            ST_SUMMARY:
            begin
                if (!sts.pend_valid || sts.slot_free)
                begin
                    cmd.sum_take = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!sts.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.slot_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/mmpbs_dp.sv]
// pattern table, byte window, row compare and result registers
module mmpbs_dp
    import mmpbs_pkg::*;
#(
    parameter int NUM_PATTERNS    = 8,
    parameter int MAX_PATTERN_LEN = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [PCOUNT_W-1:0] cfg_write_data,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [PIDX_W-1:0]   pattern_index,
    input  logic [EIDX_W-1:0]   element_index,
    input  logic [BYTE_W-1:0]   match_value,
    input  logic [BYTE_W-1:0]   mask_value,
    input  logic [PLEN_W-1:0]   pattern_length,
    input  logic [GROUP_W-1:0]  group_id,
    input  logic                start_disabled,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [PIDX_W-1:0]   match_pattern,
    output logic [OFFSET_W-1:0] match_offset,
    output logic                all_found,
    output logic                last,
    input  cmd_t                cmd,
    output sts_t                sts
);

    localparam int NP = NUM_PATTERNS;
    localparam int ML = MAX_PATTERN_LEN;
    localparam int PW = (NP > 1) ? $clog2(NP) : 1;
    localparam int EW = (ML > 1) ? $clog2(ML) : 1;
    localparam int FW = $clog2(ML + 1);
    localparam int CW = $clog2(NP + 1);

    // pattern memory, one row per pattern, element write enables
    logic [BYTE_W-1:0]   mem_match [NP][ML];
    logic [BYTE_W-1:0]   mem_mask  [NP][ML];
    logic [BYTE_W-1:0]   row_match_reg [ML];
    logic [BYTE_W-1:0]   row_mask_reg  [ML];
    logic [PW-1:0]       cur_reg;

    logic [PLEN_W-1:0]   len_reg [NP];
    logic [GROUP_W-1:0]  grp_reg [NP];
    logic [NP-1:0]       dis_reg;
    logic [PCOUNT_W-1:0] pcount_reg;

    logic [BYTE_W-1:0]   win_reg [ML];
    logic [FW-1:0]       fill_reg;
    logic [OFFSET_W-1:0] pos_reg;
    logic                fin_reg;
    logic                lastb_reg;

    logic                pend_valid_reg;
    logic                pend_kind_reg;
    logic [PIDX_W-1:0]   pend_pat_reg;
    logic [OFFSET_W-1:0] pend_off_reg;
    logic                pend_all_reg;
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic [PIDX_W-1:0]   out_pat_reg;
    logic [OFFSET_W-1:0] out_off_reg;
    logic                out_all_reg;
    logic                out_last_reg;

    logic [CW-1:0]       cnt;
    logic [NP-1:0]       act_mask;
    logic [ML-1:0]       elem_ok;
    logic [PLEN_W-1:0]   cur_len;
    logic                len_ok;
    logic                hit;
    logic [NP-1:0]       dis_hit;
    logic                fin_new;
    logic                ptr_end;
    logic [PW-1:0]       rd_addr;
    logic [OFFSET_W-1:0] cur_off;
    logic                in_elem;
    logic                in_head;
    logic                in_byte;
    logic                load;
    logic                push;
    logic                slot_free;

    assign in_elem = cmd.in_take && (op_t'(opcode) == OP_LOAD_ELEM)
                     && (int'(pattern_index) < NP) && (int'(element_index) < ML);
    assign in_head = cmd.in_take && (op_t'(opcode) == OP_LOAD_HEADER)
                     && (int'(pattern_index) < NP);
    assign in_byte = cmd.in_take && (op_t'(opcode) == OP_BYTE);

    assign cnt = (int'(pcount_reg) > NP) ? CW'(NP) : CW'(pcount_reg);

    always_comb
    begin
        for (int q = 0; q < NP; q++)
        begin
            act_mask[q] = (q < int'(cnt));
        end
    end

    // one pattern row against the whole window in parallel
    assign cur_len = len_reg[cur_reg];
    assign len_ok  = (int'(cur_len) <= ML) && (int'(cur_len) <= int'(fill_reg));

    always_comb
    begin
        for (int x = 0; x < ML; x++)
        begin
            elem_ok[x] = (x >= int'(cur_len))
                         || ((win_reg[x] & row_mask_reg[x]) == row_match_reg[x]);
        end
    end

    assign hit = !dis_reg[cur_reg] && len_ok && (&elem_ok);

    // group knock-out for the pattern under test
    always_comb
    begin
        for (int q = 0; q < NP; q++)
        begin
            dis_hit[q] = dis_reg[q]
                         || (act_mask[q] && (grp_reg[q] == grp_reg[cur_reg]));
        end
    end

    assign fin_new = &(dis_hit | ~act_mask);
    assign ptr_end = (int'(cur_reg) + 1) >= int'(cnt);
    assign rd_addr = cmd.rd_first ? '0 : PW'(int'(cur_reg) + 1);
    assign cur_off = pos_reg - OFFSET_W'(fill_reg);

    assign slot_free = !out_valid_reg || out_ready;
    assign load      = cmd.hit_take || cmd.sum_take;
    assign push      = (load && pend_valid_reg) || cmd.flush;

    assign sts.last_b     = lastb_reg;
    assign sts.fill_full  = (int'(fill_reg) == ML);
    assign sts.fill_one   = (fill_reg == FW'(1));
    assign sts.fin        = fin_reg;
    assign sts.cnt_zero   = (cnt == '0);
    assign sts.hit        = hit;
    assign sts.done       = ptr_end || (hit && fin_new);
    assign sts.pend_valid = pend_valid_reg;
    assign sts.slot_free  = slot_free;

    always_ff @(posedge clk)
    begin
        if (in_elem)
        begin
            mem_match[PW'(pattern_index)][EW'(element_index)] <= match_value;
            mem_mask[PW'(pattern_index)][EW'(element_index)]  <= mask_value;
        end
        if (cmd.rd_first || cmd.rd_next)
        begin
            row_match_reg <= mem_match[rd_addr];
            row_mask_reg  <= mem_mask[rd_addr];
            cur_reg       <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_head)
        begin
            len_reg[PW'(pattern_index)] <= pattern_length;
            grp_reg[PW'(pattern_index)] <= group_id;
        end
        if (in_byte)
        begin
            lastb_reg <= last_byte;
        end
        if (load)
        begin
            pend_kind_reg <= cmd.sum_take ? KIND_SUMMARY : KIND_MATCH;
            pend_pat_reg  <= cmd.sum_take ? '0 : PIDX_W'(cur_reg);
            pend_off_reg  <= cmd.sum_take ? pos_reg : cur_off;
            pend_all_reg  <= cmd.sum_take ? fin_reg : fin_new;
        end
        if (push)
        begin
            out_kind_reg <= pend_kind_reg;
            out_pat_reg  <= pend_pat_reg;
            out_off_reg  <= pend_off_reg;
            out_all_reg  <= pend_all_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg     <= '0;
            dis_reg        <= '1;
            fill_reg       <= '0;
            pos_reg        <= '0;
            fin_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < ML; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                pcount_reg <= cfg_write_data;
            end
            if (in_head)
            begin
                dis_reg[PW'(pattern_index)] <= start_disabled;
            end
            if (cmd.hit_take)
            begin
                dis_reg <= dis_hit;
                fin_reg <= fin_new;
            end
            if (in_byte)
            begin
                for (int i = 0; i < ML; i++)
                begin
                    if (int'(fill_reg) == i)
                    begin
                        win_reg[i] <= data_byte;
                    end
                end
                fill_reg <= fill_reg + FW'(1);
                pos_reg  <= pos_reg + OFFSET_W'(1);
            end
            if (cmd.shift)
            begin
                for (int i = 0; i < ML - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[ML-1] <= '0;
                fill_reg      <= fill_reg - FW'(1);
            end
            if (cmd.sum_take)
            begin
                for (int i = 0; i < ML; i++)
                begin
                    win_reg[i] <= '0;
                end
                fill_reg <= '0;
                pos_reg  <= '0;
                fin_reg  <= 1'b0;
            end
            if (load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            out_valid_reg <= (out_valid_reg && !out_ready) || push;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign match_pattern = out_pat_reg;
    assign match_offset  = out_off_reg;
    assign all_found     = out_all_reg;
    assign last          = out_last_reg;

endmodule

[hdl/masked_multi_pattern_byte_search.sv]
// top level of the masked multi-pattern byte search
//
//  channel  | handshake             | carries
//  ---------+-----------------------+--------------------------------------------
//  input    | in_valid / in_ready   | opcode, load fields, data_byte, last_byte
//  output   | out_valid / out_ready | kind, match_pattern, match_offset, all_found, last
//  config   | cfg_write_en          | cfg_write_data (pattern_count)
//
// a load is taken in the idle state; a buffer byte that does not fill the window only
// passes evaluate and finish; a full window reads one pattern row per cycle from the
// pattern memory unless a hit waits; the last byte runs that loop per held position
// reset clears the window, counters and result slots and disables every pattern
// a request waits while a byte runs, stalled only if output and pending slots are full
module masked_multi_pattern_byte_search
    import mmpbs_pkg::*;
#(
    parameter int NUM_PATTERNS    = 8,
    parameter int MAX_PATTERN_LEN = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [PCOUNT_W-1:0] cfg_write_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [PIDX_W-1:0]   pattern_index,
    input  logic [EIDX_W-1:0]   element_index,
    input  logic [BYTE_W-1:0]   match_value,
    input  logic [BYTE_W-1:0]   mask_value,
    input  logic [PLEN_W-1:0]   pattern_length,
    input  logic [GROUP_W-1:0]  group_id,
    input  logic                start_disabled,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind,
    output logic [PIDX_W-1:0]   match_pattern,
    output logic [OFFSET_W-1:0] match_offset,
    output logic                all_found,
    output logic                last
);

    cmd_t cmd;
    sts_t sts;

    mmpbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mmpbs_dp #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .opcode         (opcode),
        .pattern_index  (pattern_index),
        .element_index  (element_index),
        .match_value    (match_value),
        .mask_value     (mask_value),
        .pattern_length (pattern_length),
        .group_id       (group_id),
        .start_disabled (start_disabled),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .match_pattern  (match_pattern),
        .match_offset   (match_offset),
        .all_found      (all_found),
        .last           (last),
        .cmd            (cmd),
        .sts            (sts)
    );

endmodule

[hdl/mmpbs_checker.sv]
// port-level checks for the byte search, bound to the top level
module mmpbs_checker
    import mmpbs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [OPCODE_W-1:0] opcode,
    input logic                out_valid,
    input logic                out_ready,
    input logic                kind,
    input logic [PIDX_W-1:0]   match_pattern,
    input logic [OFFSET_W-1:0] match_offset,
    input logic                all_found,
    input logic                last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({kind, match_pattern, match_offset, all_found, last}))
        else $error("result changed while stalled");

    // the summary always closes its request
    a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_SUMMARY) |-> last)
        else $error("summary not marked last");

    a_sum_pat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_SUMMARY) |-> (match_pattern == '0))
        else $error("summary carries a pattern number");

    // a table load leaves the input ready again in the next cycle
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode != OP_BYTE) |=> in_ready)
        else $error("load request held up the input");

endmodule

bind masked_multi_pattern_byte_search mmpbs_checker u_chk (.*);
